### sv/qdse_pkg.sv
// shared types and constants of the quadrature decoder speed estimator
`timescale 1ns / 1ps
`default_nettype none
package qdse_pkg;

   // event codes on the request channel
   localparam logic [1:0] CMD_EDGE_A = 2'd0;
   localparam logic [1:0] CMD_EDGE_B = 2'd1;
   localparam logic [1:0] CMD_TICK   = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_MIRROR      = 2'd0;
   localparam logic [1:0] CSR_TICKS_REV   = 2'd1;
   localparam logic [1:0] CSR_MIN_INTERVAL = 2'd2;
   localparam logic [1:0] CSR_STOP_TIMEOUT = 2'd3;

   // direction codes, two bit signed
   localparam logic [1:0] DIR_STOP = 2'b00;
   localparam logic [1:0] DIR_FWD  = 2'b01;
   localparam logic [1:0] DIR_REV  = 2'b11;

   // reset values of the configuration registers
   localparam logic [15:0] TICKS_REV_RESET    = 16'd720;
   localparam logic [15:0] MIN_INTERVAL_RESET = 16'd10;
   localparam logic [15:0] STOP_TIMEOUT_RESET = 16'd100;

   // 2 * 3.14159 * 1000 scaled by 100; the q16 scale is a shift by FRAC_BITS
   localparam int unsigned SPEED_MUL_W = 20;
   localparam logic [SPEED_MUL_W-1:0] SPEED_MUL = 20'd628318;
   localparam int unsigned FRAC_BITS = 16;

   // 100 * ticks_per_rev, and times the 32 bit elapsed time
   localparam int unsigned TPR100_W = 23;
   localparam int unsigned DT_W     = 32;
   localparam int unsigned DEN_W    = TPR100_W + DT_W;
   localparam int unsigned QUO_W    = 32;

   typedef struct packed {
      logic up;
      logic down;
   } step_type;

endpackage
`default_nettype wire

### sv/quadrature_decoder_speed_estimator_top.sv
// top level: quadrature decoder with iterative speed estimation
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------------
//  request  | req_valid / req_ready | req_command, req_level_a, req_level_b, req_now_ms
//  response | rsp_valid / rsp_ready | rsp_position, rsp_speed_q16, rsp_direction
//  csr      | csr_we (no wait)      | csr_index, csr_wdata
//
//  one beat in gives one beat out. an event that recomputes speed runs 20 shift-add
//  steps of the multiply by the speed constant and 32 restoring divide steps, all on
//  one shared adder; the divide steps are skipped when the quotient overflows.
//  req_ready is high only while the sequencer is idle; a finished result waits in
//  the response register, so the next beat is taken while it is still pending.
//  synchronous active high reset clears count, time marks, held speed, config.
`timescale 1ns / 1ps
`default_nettype none
module quadrature_decoder_speed_estimator_top #(
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic        req_level_a,
   input  wire logic        req_level_b,
   input  wire logic [31:0] req_now_ms,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_position,
   output logic [31:0]      rsp_speed_q16,
   output logic [1:0]       rsp_direction,
   // configuration writes
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam int unsigned CW      = COUNT_WIDTH;
   localparam int unsigned PROD_W  = CW + qdse_pkg::SPEED_MUL_W;
   localparam int unsigned SHDEN_W = qdse_pkg::DEN_W + qdse_pkg::FRAC_BITS;
   localparam int unsigned ALU_W   = (PROD_W > SHDEN_W) ? PROD_W : SHDEN_W;
   localparam int unsigned DEN_W   = qdse_pkg::DEN_W;
   localparam int unsigned FRAC    = qdse_pkg::FRAC_BITS;
   localparam int unsigned QUO_W   = qdse_pkg::QUO_W;
   localparam int unsigned MUL_W   = qdse_pkg::SPEED_MUL_W;
   localparam int unsigned IT_W    = $clog2(QUO_W);

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PREP = 3'd1;
   localparam logic [2:0] ST_DEN  = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_CMP  = 3'd4;
   localparam logic [2:0] ST_DIV  = 3'd5;
   localparam logic [2:0] ST_FIN  = 3'd6;

   // control and architectural state
   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] cau_ff, cau_in;         // count at last speed update
   logic [31:0]   tau_ff, tau_in;         // time at last speed update
   logic [31:0]   speed_held_ff, speed_held_in;
   logic [1:0]    dir_held_ff, dir_held_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // configuration
   logic          mirror_ff;
   logic [15:0]   tpr_ff;
   logic [15:0]   min_ff;
   logic [15:0]   stop_ff;

   // datapath
   logic [31:0]                    now_ff, now_in;
   logic [31:0]                    dt_ff, dt_in;
   logic [CW-1:0]                  delta_ff, delta_in;
   logic [qdse_pkg::TPR100_W-1:0]  tpr100_ff, tpr100_in;
   logic [DEN_W-1:0]               den_ff, den_in;
   logic                           upd_ff, upd_in;
   logic                           stop_hit_ff, stop_hit_in;
   logic                           neg_ff, neg_in;
   logic                           magnz_ff, magnz_in;
   logic                           ovf_ff, ovf_in;
   logic [ALU_W-1:0]               acc_ff, acc_in;
   logic [PROD_W-1:0]              mag_sh_ff, mag_sh_in;
   logic [MUL_W-1:0]               mul_k_ff, mul_k_in;
   logic [DEN_W-1:0]               rem_ff, rem_in;
   logic [QUO_W-1:0]               src_ff, src_in;
   logic [QUO_W-1:0]               quo_ff, quo_in;
   logic [IT_W-1:0]                iter_ff, iter_in;

   // response payload
   logic [31:0] rsp_position_ff, rsp_position_in;
   logic [31:0] rsp_speed_ff, rsp_speed_in;
   logic [1:0]  rsp_dir_ff, rsp_dir_in;

   // shared adder
   logic [ALU_W-1:0] alu_a, alu_b, alu_sum;
   logic             alu_sub, alu_carry;

   // helpers
   logic                     req_fire;
   logic                     fin_fire;
   qdse_pkg::step_type       step;
   logic [15:0]              tpr_eff;
   logic [CW-1:0]            mag;
   logic [QUO_W:0]           q_mag;
   logic [31:0]              q_sat;
   logic [31:0]              speed_calc;
   logic [1:0]               dir_calc;
   logic [31:0]              speed_next;
   logic [1:0]               dir_next;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign fin_fire  = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);

   qdse_quad u_quad (
      .clock   (clock),
      .reset   (reset),
      .fire    (req_fire),
      .command (req_command),
      .level_a (req_level_a),
      .level_b (req_level_b),
      .mirror  (mirror_ff),
      .step    (step)
   );

   qdse_alu #(
      .WIDTH (ALU_W)
   ) u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .sub    (alu_sub),
      .result (alu_sum),
      .carry  (alu_carry)
   );

   // zero ticks per revolution counts as one
   assign tpr_eff = (tpr_ff == 16'd0) ? 16'd1 : tpr_ff;
   // magnitude of the signed count delta
   assign mag = delta_ff[CW-1] ? (CW'(0) - delta_ff) : delta_ff;

   // quotient saturation and sign; overflow stands for anything at or above 2^32
   always_comb begin
      q_mag = ovf_ff ? {1'b1, {QUO_W{1'b0}}} : {1'b0, quo_ff};
      q_sat = 32'h0;
      if (neg_ff) begin
         q_sat      = (q_mag > 33'h0_8000_0000) ? 32'h8000_0000 : q_mag[31:0];
         speed_calc = 32'h0 - q_sat;
         dir_calc   = qdse_pkg::DIR_REV;
      end else begin
         speed_calc = (q_mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q_mag[31:0];
         dir_calc   = magnz_ff ? qdse_pkg::DIR_FWD : qdse_pkg::DIR_STOP;
      end
      speed_next = upd_ff ? speed_calc : speed_held_ff;
      dir_next   = upd_ff ? dir_calc : dir_held_ff;
      // stop timeout wins over a fresh estimate
      if (stop_hit_ff) begin
         speed_next = 32'h0;
         dir_next   = qdse_pkg::DIR_STOP;
      end
   end

   // sequencer and datapath next state
   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      cau_in          = cau_ff;
      tau_in          = tau_ff;
      speed_held_in   = speed_held_ff;
      dir_held_in     = dir_held_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      now_in          = now_ff;
      dt_in           = dt_ff;
      delta_in        = delta_ff;
      tpr100_in       = tpr100_ff;
      den_in          = den_ff;
      upd_in          = upd_ff;
      stop_hit_in     = stop_hit_ff;
      neg_in          = neg_ff;
      magnz_in        = magnz_ff;
      ovf_in          = ovf_ff;
      acc_in          = acc_ff;
      mag_sh_in       = mag_sh_ff;
      mul_k_in        = mul_k_ff;
      rem_in          = rem_ff;
      src_in          = src_ff;
      quo_in          = quo_ff;
      iter_in         = iter_ff;
      rsp_position_in = rsp_position_ff;
      rsp_speed_in    = rsp_speed_ff;
      rsp_dir_in      = rsp_dir_ff;
      alu_a           = '0;
      alu_b           = '0;
      alu_sub         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               now_in = req_now_ms;
               if (step.up) begin
                  count_in = count_ff + CW'(1);
               end else if (step.down) begin
                  count_in = count_ff - CW'(1);
               end
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            dt_in     = now_ff - tau_ff;
            delta_in  = count_ff - cau_ff;
            tpr100_in = {1'b0, tpr_eff, 6'b0} + {2'b0, tpr_eff, 5'b0}
                      + {5'b0, tpr_eff, 2'b0};
            state_in  = ST_DEN;
         end
         ST_DEN: begin
            upd_in      = dt_ff > {16'h0, min_ff};
            stop_hit_in = dt_ff > {16'h0, stop_ff};
            neg_in      = delta_ff[CW-1];
            magnz_in    = |delta_ff;
            den_in      = DEN_W'(tpr100_ff) * DEN_W'(dt_ff);
            acc_in      = '0;
            mag_sh_in   = PROD_W'(mag);
            mul_k_in    = qdse_pkg::SPEED_MUL;
            quo_in      = '0;
            ovf_in      = 1'b0;
            // the multiply and divide are skipped when no estimate survives or the delta is zero
            if ((dt_ff > {16'h0, min_ff}) && !(dt_ff > {16'h0, stop_ff}) && (|delta_ff)) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_MUL: begin
            // shift-add over the bits of the speed constant, lsb first
            alu_a     = acc_ff;
            alu_b     = mul_k_ff[0] ? ALU_W'(mag_sh_ff) : '0;
            acc_in    = alu_sum;
            mag_sh_in = mag_sh_ff << 1;
            mul_k_in  = mul_k_ff >> 1;
            if (mul_k_ff[MUL_W-1:1] == '0) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            // product * 2^16 >= den * 2^32 means the quotient needs more than 32 bits
            alu_a   = acc_ff;
            alu_b   = ALU_W'({den_ff, {FRAC{1'b0}}});
            alu_sub = 1'b1;
            if (alu_carry) begin
               ovf_in   = 1'b1;
               state_in = ST_FIN;
            end else begin
               rem_in   = acc_ff[SHDEN_W-1:FRAC];
               src_in   = {acc_ff[FRAC-1:0], {(QUO_W-FRAC){1'b0}}};
               iter_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // restoring divide, one quotient bit a cycle
            alu_a   = ALU_W'({rem_ff, src_ff[QUO_W-1]});
            alu_b   = ALU_W'(den_ff);
            alu_sub = 1'b1;
            if (alu_carry) begin
               rem_in = alu_sum[DEN_W-1:0];
            end else begin
               rem_in = {rem_ff[DEN_W-2:0], src_ff[QUO_W-1]};
            end
            quo_in  = {quo_ff[QUO_W-2:0], alu_carry};
            src_in  = src_ff << 1;
            iter_in = iter_ff + IT_W'(1);
            if (iter_ff == '1) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (fin_fire) begin
               speed_held_in   = speed_next;
               dir_held_in     = dir_next;
               if (upd_ff) begin
                  cau_in = count_ff;
                  tau_in = now_ff;
               end
               rsp_valid_in    = 1'b1;
               rsp_position_in = 32'($signed(count_ff));
               rsp_speed_in    = speed_next;
               rsp_dir_in      = dir_next;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         cau_ff        <= '0;
         tau_ff        <= '0;
         speed_held_ff <= '0;
         dir_held_ff   <= qdse_pkg::DIR_STOP;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         cau_ff        <= cau_in;
         tau_ff        <= tau_in;
         speed_held_ff <= speed_held_in;
         dir_held_ff   <= dir_held_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // configuration registers, unknown indexes fall through
   always_ff @(posedge clock) begin
      if (reset) begin
         mirror_ff <= 1'b0;
         tpr_ff    <= qdse_pkg::TICKS_REV_RESET;
         min_ff    <= qdse_pkg::MIN_INTERVAL_RESET;
         stop_ff   <= qdse_pkg::STOP_TIMEOUT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            qdse_pkg::CSR_MIRROR:       mirror_ff <= csr_wdata[0];
            qdse_pkg::CSR_TICKS_REV:    tpr_ff    <= csr_wdata;
            qdse_pkg::CSR_MIN_INTERVAL: min_ff    <= csr_wdata;
            qdse_pkg::CSR_STOP_TIMEOUT: stop_ff   <= csr_wdata;
            default:                    mirror_ff <= mirror_ff;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      now_ff          <= now_in;
      dt_ff           <= dt_in;
      delta_ff        <= delta_in;
      tpr100_ff       <= tpr100_in;
      den_ff          <= den_in;
      upd_ff          <= upd_in;
      stop_hit_ff     <= stop_hit_in;
      neg_ff          <= neg_in;
      magnz_ff        <= magnz_in;
      ovf_ff          <= ovf_in;
      acc_ff          <= acc_in;
      mag_sh_ff       <= mag_sh_in;
      mul_k_ff        <= mul_k_in;
      rem_ff          <= rem_in;
      src_ff          <= src_in;
      quo_ff          <= quo_in;
      iter_ff         <= iter_in;
      rsp_position_ff <= rsp_position_in;
      rsp_speed_ff    <= rsp_speed_in;
      rsp_dir_ff      <= rsp_dir_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_position  = rsp_position_ff;
   assign rsp_speed_q16 = rsp_speed_ff;
   assign rsp_direction = rsp_dir_ff;

   // an accepted beat always starts the sequencer
   a_fire_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_PREP)
      else $error("accepted beat did not start the sequencer");

   // divide remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < den_ff)
      else $error("divide remainder not below divisor");

   // forward direction never carries a negative speed
   a_fwd_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_direction == qdse_pkg::DIR_FWD |-> !rsp_speed_q16[31])
      else $error("forward direction with negative speed");

   // stopped means zero speed
   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_direction == qdse_pkg::DIR_STOP |-> rsp_speed_q16 == 32'h0)
      else $error("stopped direction with nonzero speed");

endmodule
`default_nettype wire

### sv/qdse_alu.sv
// shared add and subtract unit of the speed sequencer
`timescale 1ns / 1ps
`default_nettype none
module qdse_alu #(
   parameter int unsigned WIDTH = 72
) (
   input  wire logic [WIDTH-1:0] op_a,
   input  wire logic [WIDTH-1:0] op_b,
   input  wire logic             sub,
   output logic      [WIDTH-1:0] result,
   output logic                  carry
);

   logic [WIDTH-1:0] op_b_eff;

   // carry out on subtract means op_a >= op_b
   assign op_b_eff = sub ? ~op_b : op_b;
   assign {carry, result} = {1'b0, op_a} + {1'b0, op_b_eff} + {{WIDTH{1'b0}}, sub};

endmodule
`default_nettype wire

### sv/qdse_quad.sv
// quadrature edge decoder: stored channel levels and count step
`timescale 1ns / 1ps
`default_nettype none
module qdse_quad (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fire,
   input  wire logic [1:0]        command,
   input  wire logic              level_a,
   input  wire logic              level_b,
   input  wire logic              mirror,
   output qdse_pkg::step_type     step
);

   logic a_now_ff, a_now_in;
   logic b_now_ff, b_now_in;
   logic up_raw, down_raw;

   always_comb begin
      a_now_in = a_now_ff;
      b_now_in = b_now_ff;
      up_raw   = 1'b0;
      down_raw = 1'b0;
      priority if (command == qdse_pkg::CMD_EDGE_A) begin
         a_now_in = level_a;
         if (level_a != a_now_ff) begin
            up_raw   = (level_a != b_now_ff);
            down_raw = (level_a == b_now_ff);
         end
      end else if (command == qdse_pkg::CMD_EDGE_B) begin
         b_now_in = level_b;
         if (level_b != b_now_ff) begin
            up_raw   = (level_b == a_now_ff);
            down_raw = (level_b != a_now_ff);
         end
      end else begin
         // update tick or unused code: no edge
         a_now_in = a_now_ff;
      end
   end

   // mirror swaps count direction
   assign step.up   = mirror ? down_raw : up_raw;
   assign step.down = mirror ? up_raw : down_raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_now_ff <= 1'b0;
         b_now_ff <= 1'b0;
      end else if (fire) begin
         a_now_ff <= a_now_in;
         b_now_ff <= b_now_in;
      end
   end

endmodule
`default_nettype wire

### test/quadrature_decoder_speed_estimator_top_tb.sv
// self-checking testbench for the quadrature decoder speed estimator top level
`timescale 1ns / 1ps
module quadrature_decoder_speed_estimator_top_tb;

   // the package names three event codes; the fourth acts as an update tick
   localparam logic [1:0] CMD_SPARE = 2'd3;
   // cycles without any beat before the run is declared hung
   localparam int STALL_LIMIT = 5000;

   typedef struct packed {
      logic [31:0] position;
      logic [31:0] speed_q16;
      logic [1:0]  direction;
   } reading_type;

   // tracks the decoder state and predicts each reading, then checks the beats out
   class encoder_scoreboard;
      bit        mirror     = 1'b0;
      bit [15:0] ticks_rev  = qdse_pkg::TICKS_REV_RESET;
      bit [15:0] min_gap    = qdse_pkg::MIN_INTERVAL_RESET;
      bit [15:0] stop_gap   = qdse_pkg::STOP_TIMEOUT_RESET;
      bit [31:0] count      = '0;
      bit [31:0] count_mark = '0;
      bit [31:0] time_mark  = '0;
      bit        a_lvl      = 1'b0;
      bit        b_lvl      = 1'b0;
      bit [31:0] speed_hold = '0;
      bit [1:0]  dir_hold   = qdse_pkg::DIR_STOP;
      reading_type expected_readings[$];
      int        mismatches = 0;

      function void set_reg(logic [1:0] idx, logic [15:0] value);
         case (idx)
            qdse_pkg::CSR_MIRROR:       mirror    = value[0];
            qdse_pkg::CSR_TICKS_REV:    ticks_rev = value;
            qdse_pkg::CSR_MIN_INTERVAL: min_gap   = value;
            qdse_pkg::CSR_STOP_TIMEOUT: stop_gap  = value;
            default: ;
         endcase
      endfunction

      function void note_event(logic [1:0] cmd, logic la, logic lb, logic [31:0] now);
         int         step;
         bit [31:0]  dt;
         bit [31:0]  delta;
         bit [31:0]  mag;
         bit [15:0]  tpr;
         bit [127:0] num;
         bit [127:0] den;
         bit [127:0] quo;
         step = 0;
         // the other channel comes from the stored level, not the beat
         if (cmd == qdse_pkg::CMD_EDGE_A) begin
            if (la != a_lvl) step = (la == b_lvl) ? -1 : 1;
            a_lvl = la;
         end else if (cmd == qdse_pkg::CMD_EDGE_B) begin
            if (lb != b_lvl) step = (lb == a_lvl) ? 1 : -1;
            b_lvl = lb;
         end
         if (mirror) step = -step;
         if (step > 0) count = count + 32'd1;
         else if (step < 0) count = count - 32'd1;

         // elapsed time wraps modulo 2^32
         dt = now - time_mark;
         if (dt > min_gap) begin
            delta = count - count_mark;
            mag   = delta[31] ? (~delta + 32'd1) : delta;
            tpr   = (ticks_rev == 16'd0) ? 16'd1 : ticks_rev;
            num   = (128'(mag) * 128'(qdse_pkg::SPEED_MUL)) << qdse_pkg::FRAC_BITS;
            den   = 128'(tpr) * 128'd100 * 128'(dt);
            quo   = num / den;
            if (delta[31]) begin
               if (quo > 128'h8000_0000) quo = 128'h8000_0000;
               speed_hold = ~quo[31:0] + 32'd1;
               dir_hold   = qdse_pkg::DIR_REV;
            end else begin
               if (quo > 128'h7FFF_FFFF) quo = 128'h7FFF_FFFF;
               speed_hold = quo[31:0];
               dir_hold   = (mag != 0) ? qdse_pkg::DIR_FWD : qdse_pkg::DIR_STOP;
            end
            count_mark = count;
            time_mark  = now;
         end
         // stop timeout uses the same elapsed time
         if (dt > stop_gap) begin
            speed_hold = '0;
            dir_hold   = qdse_pkg::DIR_STOP;
         end
         expected_readings.push_back({count, speed_hold, dir_hold});
      endfunction

      function void check_reading(reading_type got);
         reading_type want;
         if (expected_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected reading: position %0d speed %0d direction %0d",
                        $signed(got.position), $signed(got.speed_q16),
                        $signed(got.direction));
            return;
         end
         want = expected_readings.pop_front();
         if (got.position !== want.position || got.speed_q16 !== want.speed_q16 ||
             got.direction !== want.direction) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch exp/act: pos %0d/%0d speed %0d/%0d dir %0d/%0d",
                        $signed(want.position), $signed(got.position),
                        $signed(want.speed_q16), $signed(got.speed_q16),
                        $signed(want.direction), $signed(got.direction));
         end
      endfunction

      function int pending();
         return expected_readings.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_command;
   logic        req_level_a;
   logic        req_level_b;
   logic [31:0] req_now_ms;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_position;
   logic [31:0] rsp_speed_q16;
   logic [1:0]  rsp_direction;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   encoder_scoreboard sb;

   // stimulus side view of the stored pin levels and the running clock in ms
   logic        gen_a = 1'b0;
   logic        gen_b = 1'b0;
   logic [31:0] gen_now = '0;
   bit          send_idle = 1'b1;
   int          readings_seen = 0;
   int          quiet_cycles = 0;

   quadrature_decoder_speed_estimator_top DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_level_a   (req_level_a),
      .req_level_b   (req_level_b),
      .req_now_ms    (req_now_ms),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_position  (rsp_position),
      .rsp_speed_q16 (rsp_speed_q16),
      .rsp_direction (rsp_direction),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // offer one event beat after a random gap, hold it until taken
   task automatic send_event(input logic [1:0] cmd, input logic la, input logic lb,
                             input logic [31:0] now);
      int gap;
      int r;
      gap = 0;
      if (send_idle) begin
         r = $urandom_range(0, 99);
         if (r >= 90) gap = $urandom_range(10, 80);
         else if (r >= 55) gap = $urandom_range(1, 4);
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_level_a <= la;
      req_level_b <= lb;
      req_now_ms  <= now;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // beat taken at this edge
      sb.note_event(cmd, la, lb, now);
      if (cmd == qdse_pkg::CMD_EDGE_A) gen_a = la;
      else if (cmd == qdse_pkg::CMD_EDGE_B) gen_b = lb;
   endtask

   // one quadrature count; forward toggles A when the levels agree, else B
   task automatic quad_step(input bit fwd, input logic [31:0] now);
      if (fwd == (gen_a == gen_b))
         send_event(qdse_pkg::CMD_EDGE_A, ~gen_a, 1'($urandom_range(0, 1)), now);
      else
         send_event(qdse_pkg::CMD_EDGE_B, 1'($urandom_range(0, 1)), ~gen_b, now);
   endtask

   // stop offering and wait until every reading is back and the block is idle
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0 || !req_ready) @(posedge clock);
   endtask

   // write all four registers back to back, block idle
   task automatic set_config(input bit m, input logic [15:0] tpr, input logic [15:0] mn,
                             input logic [15:0] st);
      logic [15:0] mirror_word;
      // upper bits of the mirror write are noise the block has to drop
      mirror_word = {15'($urandom), m};
      csr_we    <= 1'b1;
      csr_index <= qdse_pkg::CSR_MIRROR;
      csr_wdata <= mirror_word;
      sb.set_reg(qdse_pkg::CSR_MIRROR, mirror_word);
      @(posedge clock);
      csr_index <= qdse_pkg::CSR_TICKS_REV;
      csr_wdata <= tpr;
      sb.set_reg(qdse_pkg::CSR_TICKS_REV, tpr);
      @(posedge clock);
      csr_index <= qdse_pkg::CSR_MIN_INTERVAL;
      csr_wdata <= mn;
      sb.set_reg(qdse_pkg::CSR_MIN_INTERVAL, mn);
      @(posedge clock);
      csr_index <= qdse_pkg::CSR_STOP_TIMEOUT;
      csr_wdata <= st;
      sb.set_reg(qdse_pkg::CSR_STOP_TIMEOUT, st);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // mostly clean quadrature motion with random time steps, plus ticks and noise
   task automatic run_events(input int n);
      int r;
      bit fwd;
      fwd = 1'b1;
      for (int i = 0; i < n; i++) begin
         // switch between bursty and gap-free offering now and then
         if (i % 32 == 0) send_idle = ($urandom_range(0, 3) != 0);
         r = $urandom_range(0, 99);
         if (r < 50) gen_now += $urandom_range(0, 2);
         else if (r < 85) gen_now += $urandom_range(0, 40);
         else if (r < 97) gen_now += $urandom_range(0, 400);
         else gen_now = $urandom();   // long jump, also crosses the wrap
         r = $urandom_range(0, 99);
         if (r < 5) fwd = !fwd;
         if (r < 70) begin
            quad_step(fwd, gen_now);
         end else if (r < 80) begin
            // tick, levels are don't care
            send_event(($urandom_range(0, 4) == 0) ? CMD_SPARE : qdse_pkg::CMD_TICK,
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), gen_now);
         end else if (r < 88) begin
            // edge that repeats the stored level
            if ($urandom_range(0, 1) != 0)
               send_event(qdse_pkg::CMD_EDGE_A, gen_a, 1'($urandom_range(0, 1)), gen_now);
            else
               send_event(qdse_pkg::CMD_EDGE_B, 1'($urandom_range(0, 1)), gen_b, gen_now);
         end else if (r < 95) begin
            // anything goes: random code and levels
            send_event(2'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       gen_now);
         end else begin
            // jitter back by one count
            quad_step(!fwd, gen_now);
         end
      end
   endtask

   // result side: random stalls, calm stretches, and one long hold-off
   initial begin
      int  hold_left;
      bit  held_once;
      bit  recv_calm;
      int  cyc;
      hold_left = 0;
      held_once = 1'b0;
      recv_calm = 1'b0;
      cyc       = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc % 200 == 0) recv_calm = ($urandom_range(0, 2) == 0);
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (!held_once && readings_seen >= 300) begin
            // long back-pressure so the request side fills and stalls
            held_once = 1'b1;
            hold_left = 600;
            rsp_ready <= 1'b0;
         end else if (!recv_calm && $urandom_range(0, 99) < 10) begin
            hold_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 60)
                                                    : $urandom_range(1, 3);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // compare every reading beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_reading({rsp_position, rsp_speed_q16, rsp_direction});
         readings_seen++;
      end
   end

   // hang detector: counts cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("no beat for %0d cycles", STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      bit          m;
      logic [15:0] tpr;
      logic [15:0] mn;
      logic [15:0] st;
      int          r;
      sb = new();
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_command <= qdse_pkg::CMD_TICK;
      req_level_a <= 1'b0;
      req_level_b <= 1'b0;
      req_now_ms  <= '0;
      csr_we      <= 1'b0;
      csr_index   <= qdse_pkg::CSR_MIRROR;
      csr_wdata   <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed, reset configuration
      send_event(qdse_pkg::CMD_TICK, 1'b1, 1'b1, 32'd0);    // nothing elapsed, all zero
      send_event(CMD_SPARE, 1'b1, 1'b1, 32'd5);     // spare code is a tick, levels ignored
      quad_step(1'b1, 32'd6);
      quad_step(1'b1, 32'd7);
      quad_step(1'b1, 32'd8);
      quad_step(1'b1, 32'd9);
      send_event(qdse_pkg::CMD_EDGE_A, gen_a, 1'b1, 32'd11); // same level, first speed update
      send_event(qdse_pkg::CMD_TICK, 1'b1, 1'b0, 32'd200);   // past the stop timeout

      // directed, one tick per rev and no minimum interval: saturation and time wrap
      drain();
      set_config(1'b0, 16'd1, 16'd0, 16'hFFFF);
      for (int k = 0; k < 7; k++) quad_step(1'b1, 32'hFFFF_FFFF);
      send_event(qdse_pkg::CMD_TICK, 1'b0, 1'b0, 32'd0);    // +6 counts in 1 ms, clamps high
      for (int k = 0; k < 7; k++) quad_step(1'b0, 32'd0);
      send_event(qdse_pkg::CMD_TICK, 1'b0, 1'b0, 32'd1);    // -7 counts in 1 ms, clamps low
      send_event(qdse_pkg::CMD_TICK, 1'b0, 1'b0, 32'd2);    // no motion
      gen_now = 32'd2;

      // random phases, each with its own register settings
      for (int phase = 0; phase < 8; phase++) begin
         drain();
         case (phase)
            0: begin m = 1'b1; tpr = 16'hFFFF; mn = 16'd0; st = 16'hFFFF; end
            1: begin m = 1'b0; tpr = 16'd0; mn = 16'd5; st = 16'd0; end
            2: begin
               m = 1'b1; tpr = 16'($urandom_range(1, 2000)); mn = 16'hFFFF; st = 16'hFFFF;
            end
            default: begin
               m = 1'($urandom_range(0, 1));
               r = $urandom_range(0, 3);
               if (r == 0) tpr = 16'd1;
               else if (r == 1) tpr = qdse_pkg::TICKS_REV_RESET;
               else if (r == 2) tpr = 16'($urandom);
               else tpr = 16'($urandom_range(1, 200));
               mn = 16'($urandom_range(0, 30));
               st = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 400));
            end
         endcase
         set_config(m, tpr, mn, st);
         run_events(128);
      end

      drain();
      repeat (60) @(posedge clock);
      if (sb.pending() != 0)
         $display("%0d readings never arrived", sb.pending());
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
